// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Field widths and default store depth
    localparam int VAL_W     = 16;
    localparam int PRI_W     = 8;
    localparam int DEPTH_DEF = 16;

    // Operation codes carried on the kind field
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic             ins;      // a word is being inserted this cycle
        logic             rem;      // the head is being removed this cycle
        logic [VAL_W-1:0] new_val;
        logic [PRI_W-1:0] new_pri;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- sv/sorted_priority_queue_core.sv -----
// Top level of the sorted priority queue: cell chain, fill count and result register.
// Sorted priority queue of DEPTH entries built as a row of cells. Every cell compares its
// own priority against the incoming one and then holds, takes the new word, or shifts
// toward a neighbor, all in the same cycle, so an insert or a remove is accepted every cycle
// and its result word appears in the output register on the next cycle. The rate is set
// by the per-cell compare and the one-deep output register: the input is stalled only
// while a result word is waiting and the output side stalls. Equal priorities
// leave in arrival order. An insert into a full queue and a remove from an empty queue
// change nothing and report status FULL and EMPTY with zero value and priority.
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_kind,
    input  wire logic [VAL_W-1:0] i_value_in,
    input  wire logic [PRI_W-1:0] i_priority_in,
    // output channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [VAL_W-1:0] o_value_out,
    output logic      [PRI_W-1:0] o_priority_out,
    output logic      [1:0]       o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_val, n_val;
    logic [PRI_W-1:0] r_pri, n_pri;
    t_status          r_status, n_status;

    logic      accept, is_full, is_empty;
    t_cell_ctl ctl;

    logic             w_ge  [DEPTH];
    logic [VAL_W-1:0] w_val [DEPTH];
    logic [PRI_W-1:0] w_pri [DEPTH];

    // Input is held off only while a result word waits on a stalled output
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    // Broadcast control to the chain
    assign ctl.ins     = accept && (t_kind'(i_kind) == KIND_INSERT) && !is_full;
    assign ctl.rem     = accept && (t_kind'(i_kind) == KIND_REMOVE) && !is_empty;
    assign ctl.new_val = i_value_in;
    assign ctl.new_pri = i_priority_in;

    // Cell chain; the head sits at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             left_ge;
        logic [VAL_W-1:0] left_val, right_val;
        logic [PRI_W-1:0] left_pri, right_pri;

        if (g == 0) begin : g_head
            assign left_ge  = 1'b1;
            assign left_val = i_value_in;
            assign left_pri = i_priority_in;
        end else begin : g_mid
            assign left_ge  = w_ge[g-1];
            assign left_val = w_val[g-1];
            assign left_pri = w_pri[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_val = w_val[g];
            assign right_pri = w_pri[g];
        end else begin : g_inner
            assign right_val = w_val[g+1];
            assign right_pri = w_pri[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (r_count > CW'(g)),
            .i_left_ge   (left_ge),
            .i_left_val  (left_val),
            .i_left_pri  (left_pri),
            .i_right_val (right_val),
            .i_right_pri (right_pri),
            .o_ge        (w_ge[g]),
            .o_val       (w_val[g]),
            .o_pri       (w_pri[g])
        );
    end

    // Fill count and result word
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_val       = r_val;
        n_pri       = r_pri;
        n_status    = r_status;
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CW'(1);
        end
        if (accept) begin
            n_out_valid = 1'b1;
            n_val       = '0;
            n_pri       = '0;
            priority if (ctl.ins) begin
                n_status = ST_INSERTED;
            end else if (ctl.rem) begin
                n_status = ST_REMOVED;
                n_val    = w_val[0];
                n_pri    = w_pri[0];
            end else if (t_kind'(i_kind) == KIND_INSERT) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_EMPTY;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_pri    <= n_pri;
        r_status <= n_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_out    = r_val;
    assign o_priority_out = r_pri;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ----- sv/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_occupied,   // slot index is below the fill count
    input  wire logic             i_left_ge,    // left neighbor stays in place on insert
    input  wire logic [VAL_W-1:0] i_left_val,
    input  wire logic [PRI_W-1:0] i_left_pri,
    input  wire logic [VAL_W-1:0] i_right_val,
    input  wire logic [PRI_W-1:0] i_right_pri,
    output logic                  o_ge,
    output logic      [VAL_W-1:0] o_val,
    output logic      [PRI_W-1:0] o_pri
);

    logic [VAL_W-1:0] r_val, n_val;
    logic [PRI_W-1:0] r_pri, n_pri;

    // Entry keeps its place if it outranks or ties the incoming priority
    assign o_ge  = i_occupied && (r_pri >= i_ctl.new_pri);
    assign o_val = r_val;
    assign o_pri = r_pri;

    // Next entry: hold, take the new word, shift down from left, or shift up from right
    always_comb begin
        n_val = r_val;
        n_pri = r_pri;
        if (i_ctl.ins && !o_ge) begin
            if (i_left_ge) begin
                n_val = i_ctl.new_val;
                n_pri = i_ctl.new_pri;
            end else begin
                n_val = i_left_val;
                n_pri = i_left_pri;
            end
        end else if (i_ctl.rem) begin
            n_val = i_right_val;
            n_pri = i_right_pri;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pri <= n_pri;
    end

endmodule

`default_nettype wire

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             i_kind,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [VAL_W-1:0] o_value_out,
    input wire logic [PRI_W-1:0] o_priority_out,
    input wire logic [1:0]       o_status
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_value_out) && $stable(o_priority_out))
        else $error("stalled result word changed");

    // Every accepted word yields a result word on the next cycle
    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted word produced no result");

    // Insert reports inserted or full, remove reports removed or empty
    a_kind_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=>
            ($past(i_kind) == KIND_INSERT ?
                (o_status == ST_INSERTED || o_status == ST_FULL) :
                (o_status == ST_REMOVED || o_status == ST_EMPTY)))
        else $error("status does not match operation");

    // Only a removal carries data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_REMOVED |-> o_value_out == '0 && o_priority_out == '0)
        else $error("non-remove result carries data");

    // Reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_kind         (i_kind),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_value_out    (o_value_out),
    .o_priority_out (o_priority_out),
    .o_status       (o_status)
);

`default_nettype wire

// ----- sim/tb_sorted_priority_queue_core.sv -----
// Self-checking testbench for the sorted priority queue core: random traffic, shadow queue.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_WAIT    = 13;
    localparam int RAND_OPS    = 450;

    // One queue operation waiting to be sent
    typedef struct {
        t_kind            kind;
        logic [VAL_W-1:0] val;
        logic [PRI_W-1:0] pri;
        bit               drain;    // hold off until every result is back
    } t_op_item;

    // One result word the core owes us
    typedef struct {
        logic [VAL_W-1:0] val;
        logic [PRI_W-1:0] pri;
        t_status          status;
    } t_result;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             kind_d    = KIND_INSERT;
    logic [VAL_W-1:0] value_d   = '0;
    logic [PRI_W-1:0] pri_d     = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [VAL_W-1:0] value_out;
    logic [PRI_W-1:0] pri_out;
    logic [1:0]       status_out;

    t_op_item ops_to_send[$];
    t_result  due_results[$];

    // Shadow copy of the sorted store, head at index 0
    logic [VAL_W-1:0] model_val [QDEPTH];
    logic [PRI_W-1:0] model_pri [QDEPTH];
    int               model_fill = 0;

    int error_count = 0;
    int cycle_count = 0;

    sorted_priority_queue_core #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind_d),
        .i_value_in     (value_d),
        .i_priority_in  (pri_d),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_value_out    (value_out),
        .o_priority_out (pri_out),
        .o_status       (status_out)
    );

    always #5 clk = ~clk;

    // Apply one accepted operation to the shadow store and queue its result
    task automatic model_apply_op(input t_kind kind, input logic [VAL_W-1:0] val,
                                  input logic [PRI_W-1:0] pri);
        t_result r;
        int      pos;
        r.val    = '0;
        r.pri    = '0;
        r.status = ST_INSERTED;
        if (kind == KIND_INSERT) begin
            if (model_fill >= QDEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new word goes behind every entry of greater or equal priority
                pos = model_fill;
                while (pos > 0 && model_pri[pos-1] < pri) begin
                    model_val[pos] = model_val[pos-1];
                    model_pri[pos] = model_pri[pos-1];
                    pos--;
                end
                model_val[pos] = val;
                model_pri[pos] = pri;
                model_fill++;
            end
        end else begin
            if (model_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.val    = model_val[0];
                r.pri    = model_pri[0];
                r.status = ST_REMOVED;
                for (int i = 1; i < model_fill; i++) begin
                    model_val[i-1] = model_val[i];
                    model_pri[i-1] = model_pri[i];
                end
                model_fill--;
            end
        end
        due_results.push_back(r);
    endtask

    task automatic add_op(input t_kind kind, input logic [VAL_W-1:0] val,
                          input logic [PRI_W-1:0] pri, input bit drain);
        t_op_item op;
        op.kind  = kind;
        op.val   = val;
        op.pri   = pri;
        op.drain = drain;
        ops_to_send.push_back(op);
    endtask

    // Input side: present queued words with random gaps between them
    t_op_item cur_op;
    int       send_gap   = 0;
    bit       send_quiet = 1'b0;

    always @(posedge clk) begin : op_driver
        bit slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            slot_free = !in_valid;
            if (in_valid && !in_stall) begin
                model_apply_op(cur_op.kind, cur_op.val, cur_op.pri);
                slot_free = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (slot_free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (ops_to_send.size() > 0 &&
                             !(ops_to_send[0].drain && due_results.size() > 0)) begin
                    cur_op = ops_to_send.pop_front();
                    in_valid <= 1'b1;
                    kind_d   <= cur_op.kind;
                    value_d  <= cur_op.val;
                    pri_d    <= cur_op.pri;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each word against the oldest expectation, stall at random
    int hold_left  = 0;
    bit recv_quiet = 1'b0;

    always @(posedge clk) begin : result_monitor
        t_result exp_r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: unexpected result word value %h priority %h status %0d",
                                 $realtime, value_out, pri_out, status_out);
                    error_count++;
                end else begin
                    exp_r = due_results.pop_front();
                    if (value_out !== exp_r.val || pri_out !== exp_r.pri ||
                        status_out !== exp_r.status) begin
                        if (error_count < 10) begin
                            $display("%0t: mismatch exp value %h priority %h status %0d",
                                     $realtime, exp_r.val, exp_r.pri, exp_r.status);
                            $display("%0t:          got value %h priority %h status %0d",
                                     $realtime, value_out, pri_out, status_out);
                        end
                        error_count++;
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    recv_quiet = !recv_quiet;
                hold_left = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int ins_pct;
        int pri_mode;
        int pick;
        t_kind            k;
        logic [PRI_W-1:0] p;

        ins_pct  = 50;
        pri_mode = 0;

        // directed: empty remove, fill with ties and extremes, full insert, partial drain
        add_op(KIND_REMOVE, 16'hFFFF, 8'hFF, 1'b0);
        add_op(KIND_INSERT, 16'h0000, 8'd0,   1'b0);
        add_op(KIND_INSERT, 16'hFFFF, 8'd255, 1'b0);
        add_op(KIND_INSERT, 16'h1234, 8'd100, 1'b0);
        add_op(KIND_INSERT, 16'h5678, 8'd100, 1'b0);
        add_op(KIND_INSERT, 16'h9ABC, 8'd100, 1'b0);
        add_op(KIND_INSERT, 16'h0001, 8'd255, 1'b0);
        add_op(KIND_INSERT, 16'h8000, 8'd0,   1'b0);
        add_op(KIND_INSERT, 16'h00FF, 8'd1,   1'b0);
        add_op(KIND_INSERT, 16'hFF00, 8'd254, 1'b0);
        add_op(KIND_INSERT, 16'hAAAA, 8'd100, 1'b0);
        add_op(KIND_INSERT, 16'h5555, 8'd128, 1'b0);
        add_op(KIND_INSERT, 16'h0F0F, 8'd127, 1'b0);
        add_op(KIND_INSERT, 16'hF0F0, 8'd0,   1'b0);
        add_op(KIND_INSERT, 16'h3C3C, 8'd255, 1'b0);
        add_op(KIND_INSERT, 16'hC3C3, 8'd1,   1'b0);
        add_op(KIND_INSERT, 16'h7FFF, 8'd100, 1'b0);
        add_op(KIND_INSERT, 16'hDEAD, 8'd255, 1'b0);
        for (int i = 0; i < 7; i++)
            add_op(KIND_REMOVE, 16'h0000, 8'd0, 1'b0);

        // random: phases of insert-heavy, balanced and remove-heavy traffic
        for (int i = 0; i < RAND_OPS; i++) begin
            if (i % 40 == 0) begin
                pick     = $urandom_range(0, 2);
                ins_pct  = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
                pri_mode = $urandom_range(0, 3);
            end
            k = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
            case (pri_mode)
                0: p = PRI_W'($urandom_range(0, 255));
                1: p = PRI_W'($urandom_range(0, 3));          // dense ties
                2: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                default: p = PRI_W'($urandom_range(250, 255));
            endcase
            add_op(k, VAL_W'($urandom_range(0, 16'hFFFF)), p,
                   (i == 0) || ($urandom_range(0, 99) == 0));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_to_send.size() > 0 || in_valid || due_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (due_results.size() > 0) begin
            $display("%0d expected result words never arrived", due_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sorted_priority_queue_core.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
sv/spq_checker.sv
sim/tb_sorted_priority_queue_core.sv
